// ----- hw/rtl/phong_vertex_shading_assert.svh -----
// Assertion macros for the Phong vertex shading block.
// Included by files that check their own logic; no dependencies.
`ifndef PHONG_VERTEX_SHADING_ASSERT_SVH
`define PHONG_VERTEX_SHADING_ASSERT_SVH
`ifndef SYNTHESIS
`define PVS_ASSERT_IMP(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("pvs: same-cycle check failed");
`define PVS_ASSERT_NXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("pvs: next-cycle check failed");
`else
`define PVS_ASSERT_IMP(lbl, ck, rs, a, c)
`define PVS_ASSERT_NXT(lbl, ck, rs, a, c)
`endif
`endif

// ----- hw/rtl/pvs_pkg.sv -----
// Shared types, constants and constant functions for the Phong vertex shader.
// No dependencies.
package pvs_pkg;

  localparam int COS_LAT = 50;
  localparam int POW_LAT = 43;

  typedef enum logic [2:0] {
    REG_AMBIENT  = 3'd0,
    REG_DIFFUSE  = 3'd1,
    REG_SPECULAR = 3'd2,
    REG_EXPONENT = 3'd3,
    REG_LIGHT_X  = 3'd4,
    REG_LIGHT_Y  = 3'd5,
    REG_LIGHT_Z  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {PW_NORMAL, PW_ONE, PW_ZERO} pw_mode_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec16_t;

  typedef struct packed {
    logic [31:0] dotm;
    logic [31:0] aa;
    logic [31:0] bb;
    logic        kill;
  } cos_in_t;

  // scale a vector down until every magnitude is below 2^15, sign kept
  function automatic vec16_t shrink3(input logic signed [63:0] a, input logic signed [63:0] b,
                                     input logic signed [63:0] c);
    logic [63:0] ma, mb, mc, mo, ra, rb, rc;
    int msb, s;
    vec16_t o;
    ma = a[63] ? 64'(-a) : 64'(a);
    mb = b[63] ? 64'(-b) : 64'(b);
    mc = c[63] ? 64'(-c) : 64'(c);
    mo = ma | mb | mc;
    msb = 0;
    for (int i = 0; i < 64; i++) begin
      if (mo[i]) msb = i;
    end
    s = (msb > 14) ? msb - 14 : 0;
    ra = ma >> s;
    rb = mb >> s;
    rc = mc >> s;
    o.x = a[63] ? 16'(-ra[15:0]) : ra[15:0];
    o.y = b[63] ? 16'(-rb[15:0]) : rb[15:0];
    o.z = c[63] ? 16'(-rc[15:0]) : rc[15:0];
    return o;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x, res, bt;
    x = v;
    res = '0;
    bt = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-j) in Q0.30, by repeated square roots
  function automatic logic [29:0] kconst(input int j);
    logic [63:0] k;
    k = 64'd1 << 29;
    for (int i = 0; i < j; i++) begin
      k = isqrt64(k << 30);
    end
    return k[29:0];
  endfunction

endpackage

// ----- hw/rtl/pvs_if.sv -----
// Handshake channels of the Phong vertex shader: vertex in, result out, register write.
// No dependencies.
interface pvs_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] view_x;
  logic signed [31:0] view_y;
  logic signed [31:0] view_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  modport source (output valid, view_x, view_y, view_z, normal_x, normal_y, normal_z,
                  input ready);
  modport sink (input valid, view_x, view_y, view_z, normal_x, normal_y, normal_z,
                output ready);
endinterface

interface pvs_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] shade;
  logic        degenerate;
  modport source (output valid, shade, degenerate, input ready);
  modport sink (input valid, shade, degenerate, output ready);
endinterface

interface pvs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/pvs_cos.sv -----
// Cosine unit: isqrt of |a|^2|b|^2 then dot*2^16/d, one bit per stage, 50 stages.
// Depends on pvs_pkg.
module pvs_cos
  import pvs_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  cos_in_t     din,
  output logic [16:0] cos
);

  logic [63:0] sx   [0:32];
  logic [63:0] sr   [0:32];
  logic [31:0] sdot [0:32];
  logic        sk   [0:32];

  always_ff @(posedge clk) begin
    if (en) begin
      sx[0]   <= din.aa * din.bb;
      sr[0]   <= '0;
      sdot[0] <= din.dotm;
      sk[0]   <= din.kill;
    end
  end

  for (genvar i = 0; i < 32; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    logic        ge;
    assign trial = sr[i] + BIT;
    assign ge    = sx[i] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sx[i+1]   <= ge ? sx[i] - trial : sx[i];
        sr[i+1]   <= ge ? (sr[i] >> 1) + BIT : sr[i] >> 1;
        sdot[i+1] <= sdot[i];
        sk[i+1]   <= sk[i];
      end
    end
  end

  logic [31:0] rem [0:17];
  logic [16:0] q   [0:17];
  logic [31:0] dv  [0:17];
  logic        dk  [0:17];

  assign rem[0] = sdot[32];
  assign q[0]   = '0;
  assign dv[0]  = sr[32][31:0];
  assign dk[0]  = sk[32];

  for (genvar m = 0; m < 17; m++) begin : g_div
    logic [32:0] sh;
    logic [32:0] df;
    logic        ge;
    assign sh = (m == 0) ? {1'b0, rem[m]} : {rem[m], 1'b0};
    assign ge = sh >= {1'b0, dv[m]};
    assign df = sh - {1'b0, dv[m]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[m+1] <= ge ? df[31:0] : sh[31:0];
        q[m+1]   <= {q[m][15:0], ge};
        dv[m+1]  <= dv[m];
        dk[m+1]  <= dk[m];
      end
    end
  end

  always_comb begin
    if (dk[17] || dv[17] == '0) begin
      cos = '0;
    end else if (q[17] > 17'd65536) begin
      cos = 17'd65536;
    end else begin
      cos = q[17];
    end
  end

endmodule

// ----- hw/rtl/pvs_pow.sv -----
// Power unit: cos^e through log2 by squaring, a Q8.8 multiply and root-of-two products.
// 43 stages. Depends on pvs_pkg.
module pvs_pow
  import pvs_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] c,
  input  logic [15:0] e,
  output logic [16:0] pw
);

  logic [3:0]  p0;
  logic [30:0] x0;
  pw_mode_t    m0;

  always_comb begin
    p0 = '0;
    for (int i = 0; i < 16; i++) begin
      if (c[i]) p0 = 4'(i);
    end
  end

  assign x0 = 31'(c[15:0]) << (5'd30 - {1'b0, p0});
  assign m0 = (e == '0) ? PW_ONE : (c == '0) ? PW_ZERO : c[16] ? PW_ONE : PW_NORMAL;

  logic [30:0] px [0:16];
  logic [15:0] pf [0:16];
  logic [3:0]  pp [0:16];
  logic [15:0] pe [0:16];
  pw_mode_t    pm [0:16];

  always_ff @(posedge clk) begin
    if (en) begin
      px[0] <= x0;
      pf[0] <= '0;
      pp[0] <= p0;
      pe[0] <= e;
      pm[0] <= m0;
    end
  end

  for (genvar i = 0; i < 16; i++) begin : g_sq
    logic [61:0] sq;
    assign sq = px[i] * px[i];
    always_ff @(posedge clk) begin
      if (en) begin
        px[i+1] <= sq[61] ? sq[61:31] : sq[60:30];
        pf[i+1] <= {pf[i][14:0], sq[61]};
        pp[i+1] <= pp[i];
        pe[i+1] <= pe[i];
        pm[i+1] <= pm[i];
      end
    end
  end

  logic [20:0] nl;
  logic [36:0] t;
  assign nl = 21'h10_0000 - {1'b0, pp[16], pf[16]};
  assign t  = nl * pe[16];

  logic [30:0] pa  [0:24];
  logic [23:0] pfb [0:24];
  logic [12:0] pti [0:24];
  pw_mode_t    pmd [0:24];

  always_ff @(posedge clk) begin
    if (en) begin
      pa[0]  <= 31'h4000_0000;
      pfb[0] <= t[23:0];
      pti[0] <= t[36:24];
      pmd[0] <= pm[16];
    end
  end

  for (genvar j = 1; j <= 24; j++) begin : g_acc
    localparam logic [29:0] KV = kconst(j);
    logic [60:0] ap;
    assign ap = pa[j-1] * KV;
    always_ff @(posedge clk) begin
      if (en) begin
        pa[j]  <= pfb[j-1][24-j] ? ap[60:30] : pa[j-1];
        pfb[j] <= pfb[j-1];
        pti[j] <= pti[j-1];
        pmd[j] <= pmd[j-1];
      end
    end
  end

  logic [30:0] sh;
  assign sh = pa[24] >> (5'd14 + pti[24][4:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (pmd[24] == PW_ONE) begin
        pw <= 17'd65536;
      end else if (pmd[24] == PW_ZERO || pti[24] >= 13'd17) begin
        pw <= '0;
      end else begin
        pw <= sh[16:0];
      end
    end
  end

endmodule

// ----- hw/rtl/phong_vertex_shading.sv -----
// Phong vertex shading: one vertex word accepted per clock when not stalled. Vertices pass
// through two parallel cosine units (square root and divide, one bit per stage), the
// specular one followed by the power unit (16 squarings and 24 root products). The whole
// pipeline holds while a result waits to be taken; registers may be written at any time
// (cfg ready is always high) but should change only while no vertex is in flight.
// Depends on pvs_pkg, pvs_if, pvs_cos, pvs_pow and phong_vertex_shading_assert.svh.
`include "phong_vertex_shading_assert.svh"
module phong_vertex_shading
  import pvs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  pvs_vtx_if.sink       vertex,
  pvs_res_if.source     result,
  pvs_cfg_if.sink       cfg
);

  localparam int TOTAL = 6 + COS_LAT + POW_LAT + 2;
  localparam int FLD   = COS_LAT + POW_LAT;

  logic [15:0]        amb, dg, sg, ex;
  logic signed [15:0] lx, ly, lz;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amb <= '0;
      dg  <= '0;
      sg  <= '0;
      ex  <= 16'd256;
      lx  <= '0;
      ly  <= '0;
      lz  <= 16'sd16384;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_AMBIENT:  amb <= cfg.data;
        REG_DIFFUSE:  dg  <= cfg.data;
        REG_SPECULAR: sg  <= cfg.data;
        REG_EXPONENT: ex  <= cfg.data;
        REG_LIGHT_X:  lx  <= cfg.data;
        REG_LIGHT_Y:  ly  <= cfg.data;
        REG_LIGHT_Z:  lz  <= cfg.data;
        default: ;
      endcase
    end
  end

  logic [TOTAL-1:0] vpipe;
  logic             en;

  assign en           = !vpipe[TOTAL-1] || result.ready;
  assign vertex.ready = en;
  assign result.valid = vpipe[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[TOTAL-2:0], vertex.valid};
    end
  end

  // stage 1: input word
  logic signed [31:0] v1x, v1y, v1z;
  vec16_t             n1;

  always_ff @(posedge clk) begin
    if (en) begin
      v1x <= vertex.view_x;
      v1y <= vertex.view_y;
      v1z <= vertex.view_z;
      n1  <= '{vertex.normal_x, vertex.normal_y, vertex.normal_z};
    end
  end

  // stage 2: L.N, scaled vectors, zero checks
  logic signed [33:0] ln2;
  vec16_t             ls2, ns2, vs2, n2;
  logic               zl2, zn2, zv2;

  always_ff @(posedge clk) begin
    if (en) begin
      ln2 <= 34'(lx * n1.x) + 34'(ly * n1.y) + 34'(lz * n1.z);
      ls2 <= shrink3(64'(lx), 64'(ly), 64'(lz));
      ns2 <= shrink3(64'(n1.x), 64'(n1.y), 64'(n1.z));
      vs2 <= shrink3(64'(v1x), 64'(v1y), 64'(v1z));
      n2  <= n1;
      zl2 <= lx == '0 && ly == '0 && lz == '0;
      zn2 <= n1 == '0;
      zv2 <= v1x == '0 && v1y == '0 && v1z == '0;
    end
  end

  // stage 3: 2(L.N)N, diffuse dot and lengths
  logic signed [49:0] m3x, m3y, m3z;
  logic signed [50:0] pr3x, pr3y, pr3z;
  logic signed [32:0] ldot3;
  logic [31:0]        laa3, lbb3;
  vec16_t             vs3;
  logic               zl3, zn3, zv3;

  assign m3x = ln2 * n2.x;
  assign m3y = ln2 * n2.y;
  assign m3z = ln2 * n2.z;

  always_ff @(posedge clk) begin
    if (en) begin
      pr3x  <= {m3x, 1'b0};
      pr3y  <= {m3y, 1'b0};
      pr3z  <= {m3z, 1'b0};
      ldot3 <= 33'(ls2.x * ns2.x) + 33'(ls2.y * ns2.y) + 33'(ls2.z * ns2.z);
      laa3  <= 32'(ls2.x * ls2.x) + 32'(ls2.y * ls2.y) + 32'(ls2.z * ls2.z);
      lbb3  <= 32'(ns2.x * ns2.x) + 32'(ns2.y * ns2.y) + 32'(ns2.z * ns2.z);
      vs3   <= vs2;
      zl3   <= zl2;
      zn3   <= zn2;
      zv3   <= zv2;
    end
  end

  // stage 4: reflection vector
  logic signed [50:0] r4x, r4y, r4z;
  logic signed [32:0] ldot4;
  logic [31:0]        laa4, lbb4;
  vec16_t             vs4;
  logic               zl4, zn4, zv4;

  always_ff @(posedge clk) begin
    if (en) begin
      r4x   <= pr3x - (51'(lx) <<< 28);
      r4y   <= pr3y - (51'(ly) <<< 28);
      r4z   <= pr3z - (51'(lz) <<< 28);
      ldot4 <= ldot3;
      laa4  <= laa3;
      lbb4  <= lbb3;
      vs4   <= vs3;
      zl4   <= zl3;
      zn4   <= zn3;
      zv4   <= zv3;
    end
  end

  // stage 5: scale R
  vec16_t             rs5, vs5;
  logic signed [32:0] ldot5;
  logic [31:0]        laa5, lbb5;
  logic               zl5, zn5, zv5, zr5;

  always_ff @(posedge clk) begin
    if (en) begin
      rs5   <= shrink3(64'(r4x), 64'(r4y), 64'(r4z));
      zr5   <= r4x == '0 && r4y == '0 && r4z == '0;
      vs5   <= vs4;
      ldot5 <= ldot4;
      laa5  <= laa4;
      lbb5  <= lbb4;
      zl5   <= zl4;
      zn5   <= zn4;
      zv5   <= zv4;
    end
  end

  // stage 6: specular dot and lengths, cosine unit words
  logic signed [32:0] rdot5, labs5;
  cos_in_t            dci6, sci6;
  logic [1:0]         fl6;

  assign rdot5 = 33'(rs5.x * vs5.x) + 33'(rs5.y * vs5.y) + 33'(rs5.z * vs5.z);
  assign labs5 = ldot5[32] ? -ldot5 : ldot5;

  always_ff @(posedge clk) begin
    if (en) begin
      dci6.dotm <= labs5[31:0];
      dci6.aa   <= laa5;
      dci6.bb   <= lbb5;
      dci6.kill <= zl5 || zn5;
      sci6.dotm <= rdot5[31:0];
      sci6.aa   <= 32'(rs5.x * rs5.x) + 32'(rs5.y * rs5.y) + 32'(rs5.z * rs5.z);
      sci6.bb   <= 32'(vs5.x * vs5.x) + 32'(vs5.y * vs5.y) + 32'(vs5.z * vs5.z);
      sci6.kill <= rdot5[32] || rdot5 == '0 || zr5 || zv5;
      fl6       <= {zl5 || zn5 || zr5 || zv5, zr5 || zv5};
    end
  end

  logic [16:0] dcos, scos, pw;

  pvs_cos u_dcos (.clk(clk), .en(en), .din(dci6), .cos(dcos));
  pvs_cos u_scos (.clk(clk), .en(en), .din(sci6), .cos(scos));
  pvs_pow u_pow  (.clk(clk), .en(en), .c(scos), .e(ex), .pw(pw));

  logic [16:0] dd [0:POW_LAT-1];
  logic [1:0]  fl [0:FLD-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= dcos;
      fl[0] <= fl6;
      for (int k = 1; k < POW_LAT; k++) dd[k] <= dd[k-1];
      for (int k = 1; k < FLD; k++) fl[k] <= fl[k-1];
    end
  end

  // terms and saturated sum
  logic [32:0] dprod, sprod;
  logic [16:0] dterm, sterm;
  logic        dgn;
  logic [17:0] sum;

  assign dprod = dg * dd[POW_LAT-1];
  assign sprod = sg * pw;
  assign sum   = 18'(amb) + 18'(dterm) + 18'(sterm);

  always_ff @(posedge clk) begin
    if (en) begin
      dterm <= dprod[32:16];
      sterm <= fl[FLD-1][0] ? 17'd0 : sprod[32:16];
      dgn   <= fl[FLD-1][1];
      result.shade      <= (sum > 18'd65535) ? 16'hFFFF : sum[15:0];
      result.degenerate <= dgn;
    end
  end

  `PVS_ASSERT_NXT(a_stall_freeze, clk, rst, !en, $stable(vpipe))
  `PVS_ASSERT_NXT(a_accept_enters, clk, rst, vertex.valid && vertex.ready, vpipe[0])
  `PVS_ASSERT_IMP(a_no_accept_on_stall, clk, rst, result.valid && !result.ready, !vertex.ready)

endmodule

// ----- dv/phong_vertex_shading_tb_if.sv -----
`timescale 1ns / 100ps
// Testbench-side types only: the channel interfaces themselves live in the RTL (pvs_if.sv).
// No dependencies; holds the stimulus word type.
package pvs_tb_pkg;
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } vertex_word_t;
endpackage

// ----- dv/phong_shade_checker.sv -----
`timescale 1ns / 100ps
// Shading predictor and scoreboard: watches the vertex, result and register channels.
// Depends on pvs_pkg and pvs_if.
module phong_shade_checker
  import pvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pvs_vtx_if          vertex,
  pvs_res_if          result,
  pvs_cfg_if          cfg,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [15:0] shade;
    logic        degenerate;
  } shade_word_t;

  logic [15:0] amb, dif, spc, expo;
  logic signed [15:0] lx, ly, lz;
  shade_word_t shade_q[$];

  typedef longint signed v3_t[3];

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absv(longint signed v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint unsigned cos_q16(v3_t a0, v3_t b0, bit two_sided);
    longint signed a[3], b[3], dot;
    longint unsigned aa, bb, d, q, mx;
    int s;
    dot = 0; aa = 0; bb = 0;
    for (int v = 0; v < 2; v++) begin
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        q = absv(v == 0 ? a0[i] : b0[i]);
        if (q > mx) mx = q;
      end
      s = 0;
      while ((mx >> s) >= 32768) s++;
      for (int i = 0; i < 3; i++) begin
        if (v == 0) a[i] = a0[i] < 0 ? -longint'(absv(a0[i]) >> s) : longint'(absv(a0[i]) >> s);
        else b[i] = b0[i] < 0 ? -longint'(absv(b0[i]) >> s) : longint'(absv(b0[i]) >> s);
      end
    end
    for (int i = 0; i < 3; i++) begin
      dot += a[i] * b[i];
      aa += a[i] * a[i];
      bb += b[i] * b[i];
    end
    if (two_sided) dot = dot < 0 ? -dot : dot;
    else if (dot <= 0) return 0;
    d = root64(aa * bb);
    if (d == 0) return 0;
    q = (longint'(dot) << 16) / d;
    return q > 65536 ? 65536 : q;
  endfunction

  function automatic longint unsigned pow_q16(longint unsigned c, longint unsigned e);
    longint unsigned x, frac, nl, t, ti, f, acc, k;
    int p;
    if (e == 0) return 65536;
    if (c == 0) return 0;
    if (c >= 65536) return 65536;
    p = 0;
    while ((c >> (p + 1)) != 0) p++;
    x = c << (30 - p);
    frac = 0;
    for (int j = 0; j < 16; j++) begin
      x = (x * x) >> 30;
      frac <<= 1;
      if (x >= (64'd1 << 31)) begin
        frac |= 1;
        x >>= 1;
      end
    end
    nl = (64'd16 << 16) - ((longint'(p) << 16) + frac);
    t = nl * e;
    ti = t >> 24;
    f = t & 64'hFFFFFF;
    if (ti >= 17) return 0;
    acc = 64'd1 << 30;
    k = 64'd1 << 29;
    for (int j = 1; j <= 24; j++) begin
      k = root64(k << 30);
      if ((f >> (24 - j)) & 1) acc = (acc * k) >> 30;
    end
    return acc >> (14 + ti);
  endfunction

  function automatic shade_word_t shade_of(longint signed vx, vy, vz, nx, ny, nz);
    v3_t lv, nv, vv, rv;
    longint signed ln;
    longint unsigned d, s, sum;
    shade_word_t o;
    lv = '{longint'(lx), longint'(ly), longint'(lz)};
    nv = '{nx, ny, nz};
    vv = '{vx, vy, vz};
    ln = 0; d = 0; s = 0;
    o.degenerate = 0;
    for (int i = 0; i < 3; i++) ln += lv[i] * nv[i];
    for (int i = 0; i < 3; i++) rv[i] = 2 * ln * nv[i] - lv[i] * 64'sd268435456;
    if ((lv[0] == 0 && lv[1] == 0 && lv[2] == 0) || (nx == 0 && ny == 0 && nz == 0))
      o.degenerate = 1;
    else
      d = (64'(dif) * cos_q16(lv, nv, 1)) >> 16;
    if ((rv[0] == 0 && rv[1] == 0 && rv[2] == 0) || (vx == 0 && vy == 0 && vz == 0))
      o.degenerate = 1;
    else
      s = (64'(spc) * pow_q16(cos_q16(rv, vv, 0), 64'(expo))) >> 16;
    sum = 64'(amb) + d + s;
    o.shade = sum > 65535 ? 16'hFFFF : sum[15:0];
    return o;
  endfunction

  always @(posedge clk) begin
    shade_word_t e;
    if (rst) begin
      amb <= 0; dif <= 0; spc <= 0; expo <= 16'd256;
      lx <= 0; ly <= 0; lz <= 16'sd16384;
      fail_count <= 0;
      shade_q.delete();
    end else begin
      if (vertex.valid && vertex.ready)
        shade_q.push_back(shade_of(vertex.view_x, vertex.view_y, vertex.view_z,
                                   vertex.normal_x, vertex.normal_y, vertex.normal_z));
      if (result.valid && result.ready) begin
        if (shade_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word shade=%0d", result.shade);
          fail_count <= fail_count + 1;
        end else begin
          e = shade_q.pop_front();
          if (e.shade !== result.shade || e.degenerate !== result.degenerate) begin
            if (fail_count < 10)
              $display("mismatch: exp shade=%0d degen=%0b, got shade=%0d degen=%0b",
                       e.shade, e.degenerate, result.shade, result.degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_AMBIENT:  amb <= cfg.data;
          REG_DIFFUSE:  dif <= cfg.data;
          REG_SPECULAR: spc <= cfg.data;
          REG_EXPONENT: expo <= cfg.data;
          REG_LIGHT_X:  lx <= cfg.data;
          REG_LIGHT_Y:  ly <= cfg.data;
          REG_LIGHT_Z:  lz <= cfg.data;
          default: ;
        endcase
      end
    end
    pending <= shade_q.size();
  end
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Top of the shading testbench: clock, reset, register phases, vertex stimulus, verdict.
// Depends on pvs_pkg, pvs_if, pvs_tb_pkg, phong_shade_checker and phong_vertex_shading.
module tb;
  import pvs_pkg::*;
  import pvs_tb_pkg::*;

  localparam int LATENCY = 101;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   stall_mode;

  pvs_vtx_if vertex();
  pvs_res_if result();
  pvs_cfg_if cfg();

  phong_vertex_shading uut (.clk(clk), .rst(rst), .vertex(vertex), .result(result), .cfg(cfg));
  phong_shade_checker chk (.clk(clk), .rst(rst), .vertex(vertex), .result(result), .cfg(cfg),
                           .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  // receiver stall pattern: phases of none, light and heavy back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 0;
    end else begin
      case (stall_mode)
        0: result.ready <= 1;
        1: result.ready <= ($urandom_range(0, 3) != 0);
        default: result.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_light(input logic [15:0] x, y, z);
    write_reg(REG_LIGHT_X, x);
    write_reg(REG_LIGHT_Y, y);
    write_reg(REG_LIGHT_Z, z);
  endtask

  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // sends one vertex word, holding valid high across back-to-back words when keep is set
  task automatic send_vertex(input vertex_word_t w, input bit keep);
    vertex.valid <= 1;
    {vertex.view_x, vertex.view_y, vertex.view_z,
     vertex.normal_x, vertex.normal_y, vertex.normal_z} <= w;
    @(posedge clk);
    while (!vertex.ready) @(posedge clk);
    if (!keep) begin
      vertex.valid <= 0;
      @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_comp16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 0;
      3: return 16'($signed($urandom_range(0, 32767)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_comp32();
    case ($urandom_range(0, 6))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 0;
      3: return 32'($signed($urandom_range(0, 2000)) - 1000);
      4: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
      default: return $urandom;
    endcase
  endfunction

  function automatic vertex_word_t rand_vertex();
    vertex_word_t w;
    w.vx = rand_comp32(); w.vy = rand_comp32(); w.vz = rand_comp32();
    w.nx = rand_comp16(); w.ny = rand_comp16(); w.nz = rand_comp16();
    if ($urandom_range(0, 30) == 0) {w.vx, w.vy, w.vz} = '0;
    if ($urandom_range(0, 30) == 0) {w.nx, w.ny, w.nz} = '0;
    return w;
  endfunction

  task automatic random_phase(input int n);
    int gap, burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          vertex.valid <= 0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      send_vertex(rand_vertex(), burst != 0 && i != n - 1);
    end
  endtask

  initial begin
    rst = 1;
    stall_mode = 0;
    vertex.valid = 0;
    {vertex.view_x, vertex.view_y, vertex.view_z} = '0;
    {vertex.normal_x, vertex.normal_y, vertex.normal_z} = '0;
    cfg.valid = 0; cfg.index = '0; cfg.data = '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset values first: two directed words
    send_vertex('{32'sd65536, 0, 32'sd65536, 0, 0, 16'sd16384}, 0);
    send_vertex('0, 0);
    settle();

    write_reg(REG_AMBIENT, 16'd1024);
    write_reg(REG_DIFFUSE, 16'd4096);
    write_reg(REG_SPECULAR, 16'd4096);
    write_reg(REG_EXPONENT, 16'd2560);
    write_light(16'sd9459, 16'sd9459, 16'sd9459);
    send_vertex('{0, 0, 32'sd65536, 0, 0, 16'sd16384}, 1);
    send_vertex('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h7FFF, 16'h8000, 16'h7FFF}, 1);
    send_vertex('{32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000}, 1);
    send_vertex('{1, 0, 0, 16'sd1, 0, 0}, 1);
    send_vertex('{0, 0, 0, 16'sd100, 16'sd200, 16'sd300}, 1);
    send_vertex('{5, 7, 9, 0, 0, 0}, 1);
    send_vertex('{-32'sd65536, 0, 0, 0, 0, -16'sd16384}, 0);
    settle();

    // light along the normal: reflection lies along it too
    write_light(0, 0, 16'sd8192);
    send_vertex('{0, 0, 32'sd65536, 0, 0, 16'sd16384}, 0);
    settle();
    // exponent zero, zero light, saturating gains
    write_reg(REG_EXPONENT, 16'd0);
    write_light(0, 0, 0);
    write_reg(REG_AMBIENT, 16'hFFFF);
    write_reg(REG_DIFFUSE, 16'hFFFF);
    write_reg(REG_SPECULAR, 16'hFFFF);
    write_reg(REG_LIGHT_X, 16'd0);
    send_vertex('{0, 32'sd65536, 0, 16'sd16384, 0, 0}, 1);
    send_vertex('{32'sd3, -32'sd3, 32'sd3, 16'sd5, 0, 0}, 0);
    settle();
    write_light(16'h8000, 16'h7FFF, 16'h8000);
    write_reg(REG_EXPONENT, 16'd1);
    send_vertex('{32'sd12345, -32'sd5, 32'sd777, 16'sd300, 16'sd1, -16'sd2}, 1);
    send_vertex('{-32'sd1, 32'sd1, 32'sd1, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 0);
    settle();
    cfg.valid <= 1; cfg.index <= 3'd7; cfg.data <= 16'h1234;
    @(posedge clk);
    cfg.valid <= 0;
    @(posedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_AMBIENT, ph == 0 ? 16'd0 : ph == 1 ? 16'hFFFF : 16'($urandom_range(0, 8191)));
      write_reg(REG_DIFFUSE, ph == 1 ? 16'd0 : ph == 2 ? 16'hFFFF : 16'($urandom));
      write_reg(REG_SPECULAR, ph == 3 ? 16'hFFFF : 16'($urandom));
      write_reg(REG_EXPONENT, ph == 0 ? 16'hFFFF : ph == 4 ? 16'd0 : ph == 5 ? 16'd128
                : 16'($urandom_range(1, 16384)));
      write_light(rand_comp16(), rand_comp16(), ph == 2 ? 16'h8000 : rand_comp16());
      random_phase(150);
      settle();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pvs_pkg.sv
hw/rtl/pvs_if.sv
hw/rtl/pvs_cos.sv
hw/rtl/pvs_pow.sv
hw/rtl/phong_vertex_shading.sv
dv/phong_vertex_shading_tb_if.sv
dv/phong_shade_checker.sv
dv/tb.sv
